/* hdl/file_entry_table_with_block_allocator_top_macros.svh */
// Assertion macros shared by the checker of the file entry table
`ifndef FILE_ENTRY_TABLE_WITH_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FILE_ENTRY_TABLE_WITH_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define FETBA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fetba: same-cycle check failed");

// next-cycle implication, disabled during reset
`define FETBA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fetba: next-cycle check failed");

`endif

/* hdl/fetba_pkg.sv */
// Package: request/response types, status codes and control structs
`timescale 1ns / 1ps
package fetba_pkg;

    localparam int FILE_ID_W = 16;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_CREATE = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXISTS    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NO_BLOCK  = 3'd4;

    typedef struct packed {
        logic [1:0]           kind;
        logic [FILE_ID_W-1:0] file_id;
    } t_req;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] entry_index;
        logic [3:0] block_number;
        logic       block_valid;
    } t_rsp;

    // running result of the scan, handed from cell to cell
    typedef struct packed {
        logic found;
        logic has_blk;
        logic free_e;
        logic free_b;
    } t_scan_flags;

    // write-back command broadcast to all cells
    typedef struct packed {
        logic entry_set;
        logic entry_clr;
        logic has_block;
        logic block_set;
        logic block_clr;
    } t_wr_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WB
    } t_state;

endpackage

/* hdl/fetba_cell.sv */
// One table cell: a file entry, one block-used bit and one scan stage
`timescale 1ns / 1ps
module fetba_cell #(
    parameter int ENTRIES  = 16,
    parameter int KEY_W    = 16,
    parameter int CELL_IDX = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [KEY_W-1:0]         i_key,
    input  logic                     i_tok,
    input  fetba_pkg::t_scan_flags   i_flags,
    input  logic [$clog2(ENTRIES)-1:0] i_match_idx,
    input  logic [$clog2(ENTRIES)-1:0] i_match_blk,
    input  logic [$clog2(ENTRIES)-1:0] i_free_e_idx,
    input  logic [$clog2(ENTRIES)-1:0] i_free_b_idx,
    output logic                     o_tok,
    output fetba_pkg::t_scan_flags   o_flags,
    output logic [$clog2(ENTRIES)-1:0] o_match_idx,
    output logic [$clog2(ENTRIES)-1:0] o_match_blk,
    output logic [$clog2(ENTRIES)-1:0] o_free_e_idx,
    output logic [$clog2(ENTRIES)-1:0] o_free_b_idx,
    input  fetba_pkg::t_wr_ctl       i_wr,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_entry_idx,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_blk_idx
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] ME = IDX_W'(CELL_IDX);

    logic             r_valid;
    logic             r_has_blk;
    logic             r_used;
    logic [KEY_W-1:0] r_key;
    logic [IDX_W-1:0] r_blk;

    logic                   r_tok;
    fetba_pkg::t_scan_flags r_flags;
    logic [IDX_W-1:0]       r_match_idx;
    logic [IDX_W-1:0]       r_match_blk;
    logic [IDX_W-1:0]       r_free_e_idx;
    logic [IDX_W-1:0]       r_free_b_idx;

    fetba_pkg::t_scan_flags n_flags;
    logic [IDX_W-1:0]       n_match_idx;
    logic [IDX_W-1:0]       n_match_blk;
    logic [IDX_W-1:0]       n_free_e_idx;
    logic [IDX_W-1:0]       n_free_b_idx;

    logic sel_e;
    logic sel_b;

    assign sel_e = (i_wr_entry_idx == ME);
    assign sel_b = (i_wr_blk_idx == ME);

    // fold this cell into the running scan result
    always_comb begin
        n_flags      = i_flags;
        n_match_idx  = i_match_idx;
        n_match_blk  = i_match_blk;
        n_free_e_idx = i_free_e_idx;
        n_free_b_idx = i_free_b_idx;
        if (r_valid && (r_key == i_key) && !i_flags.found) begin
            n_flags.found   = 1'b1;
            n_flags.has_blk = r_has_blk;
            n_match_idx     = ME;
            n_match_blk     = r_blk;
        end
        // last free entry seen wins: highest index
        if (!r_valid) begin
            n_flags.free_e = 1'b1;
            n_free_e_idx   = ME;
        end
        // first free block seen wins: lowest index
        if (!r_used && !i_flags.free_b) begin
            n_flags.free_b = 1'b1;
            n_free_b_idx   = ME;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_has_blk <= 1'b0;
            r_used    <= (CELL_IDX < 2);
            r_tok     <= 1'b0;
            r_flags   <= '0;
        end else begin
            r_tok <= i_tok;
            if (i_tok) begin
                r_flags <= n_flags;
            end
            if (i_wr.entry_set && sel_e) begin
                r_valid   <= 1'b1;
                r_has_blk <= i_wr.has_block;
            end
            if (i_wr.entry_clr && sel_e) begin
                r_valid   <= 1'b0;
                r_has_blk <= 1'b0;
            end
            if (i_wr.block_set && sel_b) begin
                r_used <= 1'b1;
            end
            if (i_wr.block_clr && sel_b) begin
                r_used <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_match_idx  <= n_match_idx;
            r_match_blk  <= n_match_blk;
            r_free_e_idx <= n_free_e_idx;
            r_free_b_idx <= n_free_b_idx;
        end
        if (i_wr.entry_set && sel_e) begin
            r_key <= i_key;
            if (i_wr.has_block) begin
                r_blk <= i_wr_blk_idx;
            end
        end
    end

    assign o_tok        = r_tok;
    assign o_flags      = r_flags;
    assign o_match_idx  = r_match_idx;
    assign o_match_blk  = r_match_blk;
    assign o_free_e_idx = r_free_e_idx;
    assign o_free_b_idx = r_free_b_idx;

endmodule

/* hdl/file_entry_table_with_block_allocator_top.sv */
// File entry table with free-block bitmap: request control and cell chain
//
// Usage:
//   Request channel (i_req_valid / o_req_ready, payload i_req): lookup,
//   create or delete of a file id. Response channel (o_rsp_valid /
//   i_rsp_ready, payload o_rsp): status, entry index, block number and
//   block-valid flag, one response per request, in order.
//   Each cell holds one entry and one block-used bit. A request is scanned
//   through the chain one cell per cycle, and its result is taken from the
//   last cell into the output register. A new request is taken only after
//   the response to the previous one has been loaded.
//   The table update is written back in the cycle the response is loaded.
//   If the receiver stalls, the finished response waits in the output
//   register; the next request is still taken and scanned, and only its
//   write-back waits until the output register is free.
//   Reset (synchronous, active low) clears every entry and marks blocks
//   0 and 1 as used; the block is ready for requests right after reset.
`timescale 1ns / 1ps
module file_entry_table_with_block_allocator_top #(
    parameter int ENTRIES  = 16,
    parameter int ID_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  fetba_pkg::t_req i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output fetba_pkg::t_rsp o_rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int KEY_W = (ID_WIDTH < fetba_pkg::FILE_ID_W) ? ID_WIDTH
                                                             : fetba_pkg::FILE_ID_W;

    fetba_pkg::t_state r_state;
    fetba_pkg::t_state n_state;

    logic             r_go;
    logic [1:0]       r_kind;
    logic [KEY_W-1:0] r_key;

    logic            r_rsp_valid;
    logic            n_rsp_valid;
    fetba_pkg::t_rsp r_rsp;
    fetba_pkg::t_rsp n_rsp;

    logic                   tok         [ENTRIES+1];
    fetba_pkg::t_scan_flags flags       [ENTRIES+1];
    logic [IDX_W-1:0]       match_idx   [ENTRIES+1];
    logic [IDX_W-1:0]       match_blk   [ENTRIES+1];
    logic [IDX_W-1:0]       free_e_idx  [ENTRIES+1];
    logic [IDX_W-1:0]       free_b_idx  [ENTRIES+1];

    fetba_pkg::t_wr_ctl wr;
    logic [IDX_W-1:0]   wr_entry_idx;
    logic [IDX_W-1:0]   wr_blk_idx;

    logic accept;
    logic done;
    logic fire;

    fetba_pkg::t_scan_flags f;

    assign o_req_ready = (r_state == fetba_pkg::S_IDLE);
    assign accept      = i_req_valid && o_req_ready;

    assign tok[0]        = r_go;
    assign flags[0]      = '0;
    assign match_idx[0]  = '0;
    assign match_blk[0]  = '0;
    assign free_e_idx[0] = '0;
    assign free_b_idx[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        fetba_cell #(
            .ENTRIES  (ENTRIES),
            .KEY_W    (KEY_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_key          (r_key),
            .i_tok          (tok[g]),
            .i_flags        (flags[g]),
            .i_match_idx    (match_idx[g]),
            .i_match_blk    (match_blk[g]),
            .i_free_e_idx   (free_e_idx[g]),
            .i_free_b_idx   (free_b_idx[g]),
            .o_tok          (tok[g+1]),
            .o_flags        (flags[g+1]),
            .o_match_idx    (match_idx[g+1]),
            .o_match_blk    (match_blk[g+1]),
            .o_free_e_idx   (free_e_idx[g+1]),
            .o_free_b_idx   (free_b_idx[g+1]),
            .i_wr           (wr),
            .i_wr_entry_idx (wr_entry_idx),
            .i_wr_blk_idx   (wr_blk_idx)
        );
    end

    assign f = flags[ENTRIES];

    // last cell holds its result, so write-back may wait in S_WB
    assign done = ((r_state == fetba_pkg::S_SCAN) && tok[ENTRIES])
               || (r_state == fetba_pkg::S_WB);
    assign fire = done && (!r_rsp_valid || i_rsp_ready);

    always_comb begin
        n_state      = r_state;
        n_rsp_valid  = r_rsp_valid && !i_rsp_ready;
        n_rsp        = r_rsp;
        wr           = '0;
        wr_entry_idx = '0;
        wr_blk_idx   = '0;

        unique case (r_state)
            fetba_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = fetba_pkg::S_SCAN;
                end
            end
            fetba_pkg::S_SCAN, fetba_pkg::S_WB: begin
                if (done) begin
                    n_state = fire ? fetba_pkg::S_IDLE : fetba_pkg::S_WB;
                end
            end
            default: begin
                n_state = fetba_pkg::S_IDLE;
            end
        endcase

        if (fire) begin
            n_rsp_valid = 1'b1;
            n_rsp       = '0;
            n_rsp.status = fetba_pkg::ST_NOT_FOUND;
            unique case (r_kind)
                fetba_pkg::KIND_LOOKUP: begin
                    if (f.found) begin
                        n_rsp.status       = fetba_pkg::ST_OK;
                        n_rsp.entry_index  = 4'(match_idx[ENTRIES]);
                        n_rsp.block_number = f.has_blk ? 4'(match_blk[ENTRIES]) : 4'd0;
                        n_rsp.block_valid  = f.has_blk;
                    end
                end
                fetba_pkg::KIND_CREATE: begin
                    if (f.found) begin
                        n_rsp.status       = fetba_pkg::ST_EXISTS;
                        n_rsp.entry_index  = 4'(match_idx[ENTRIES]);
                        n_rsp.block_number = f.has_blk ? 4'(match_blk[ENTRIES]) : 4'd0;
                        n_rsp.block_valid  = f.has_blk;
                    end else if (!f.free_e) begin
                        n_rsp.status = fetba_pkg::ST_FULL;
                    end else begin
                        wr.entry_set      = 1'b1;
                        wr_entry_idx      = free_e_idx[ENTRIES];
                        n_rsp.entry_index = 4'(free_e_idx[ENTRIES]);
                        if (f.free_b) begin
                            wr.has_block       = 1'b1;
                            wr.block_set       = 1'b1;
                            wr_blk_idx         = free_b_idx[ENTRIES];
                            n_rsp.status       = fetba_pkg::ST_OK;
                            n_rsp.block_number = 4'(free_b_idx[ENTRIES]);
                            n_rsp.block_valid  = 1'b1;
                        end else begin
                            n_rsp.status = fetba_pkg::ST_NO_BLOCK;
                        end
                    end
                end
                fetba_pkg::KIND_DELETE: begin
                    if (f.found) begin
                        wr.entry_clr       = 1'b1;
                        wr_entry_idx       = match_idx[ENTRIES];
                        n_rsp.status       = fetba_pkg::ST_OK;
                        n_rsp.entry_index  = 4'(match_idx[ENTRIES]);
                        n_rsp.block_number = f.has_blk ? 4'(match_blk[ENTRIES]) : 4'd0;
                        n_rsp.block_valid  = f.has_blk;
                        if (f.has_blk) begin
                            wr.block_clr = 1'b1;
                            wr_blk_idx   = match_blk[ENTRIES];
                        end
                    end
                end
                default: begin
                    // unused kind: matches nothing
                    n_rsp.status = fetba_pkg::ST_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fetba_pkg::S_IDLE;
            r_go        <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_go        <= accept;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_req.kind;
            r_key  <= i_req.file_id[KEY_W-1:0];
        end
        r_rsp <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

/* hdl/fetba_chk.sv */
// Port-level checker for the file entry table, bound to the top level
`timescale 1ns / 1ps
`include "file_entry_table_with_block_allocator_top_macros.svh"
module fetba_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            o_req_ready,
    input fetba_pkg::t_req i_req,
    input logic            o_rsp_valid,
    input logic            i_rsp_ready,
    input fetba_pkg::t_rsp o_rsp
);

    // one request in flight: ready drops once a request is taken
    `FETBA_ASSERT_NEXT(a_busy_after_take, i_req_valid && o_req_ready, !o_req_ready)

    `FETBA_ASSERT_NOW(a_status_range, o_rsp_valid,
        o_rsp.status == fetba_pkg::ST_OK || o_rsp.status == fetba_pkg::ST_EXISTS ||
        o_rsp.status == fetba_pkg::ST_NOT_FOUND || o_rsp.status == fetba_pkg::ST_FULL ||
        o_rsp.status == fetba_pkg::ST_NO_BLOCK)

    // refusals carry no entry and no block
    `FETBA_ASSERT_NOW(a_refusal_empty,
        o_rsp_valid && (o_rsp.status == fetba_pkg::ST_NOT_FOUND ||
                        o_rsp.status == fetba_pkg::ST_FULL),
        o_rsp.entry_index == 4'd0 && o_rsp.block_number == 4'd0 && !o_rsp.block_valid)

    `FETBA_ASSERT_NOW(a_no_block_zero, o_rsp_valid && !o_rsp.block_valid,
        o_rsp.block_number == 4'd0)

    `FETBA_ASSERT_NEXT(a_rsp_hold, o_rsp_valid && !i_rsp_ready,
        o_rsp_valid && $stable(o_rsp))

endmodule

bind file_entry_table_with_block_allocator_top fetba_chk u_fetba_chk (.*);

/* test/file_entry_table_with_block_allocator_top_tb.sv */
// Testbench for the file entry table: random and directed requests checked against a table model
`timescale 1ns / 1ps
module file_entry_table_with_block_allocator_top_tb;

    localparam int ENTRIES = 16;
    localparam int ID_WIDTH = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_REQS = 2000;
    localparam int SEGMENT_LEN = 250;
    localparam int POOL_SIZE = 24;
    localparam int QUIET_TAIL = 300;
    localparam int DRAIN_CYCLES = 3 * (ENTRIES + 2);
    // kind code that the table does not decode
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    fetba_pkg::t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready;
    fetba_pkg::t_rsp o_rsp;

    file_entry_table_with_block_allocator_top #(
        .ENTRIES(ENTRIES),
        .ID_WIDTH(ID_WIDTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req(i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp(o_rsp)
    );

    // table model
    logic                            tbl_valid[ENTRIES];
    logic [fetba_pkg::FILE_ID_W-1:0] tbl_id[ENTRIES];
    logic [3:0]                      tbl_blk[ENTRIES];
    logic                            tbl_has_blk[ENTRIES];
    logic                            blk_used[ENTRIES];

    fetba_pkg::t_req pending_reqs[$];
    fetba_pkg::t_rsp expected_rsps[$];
    logic req_taken;
    int   req_gap;
    int   rsp_stall;
    int   mismatches;
    int   cycle_cnt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic fetba_pkg::t_rsp entry_view(logic [2:0] st, int e);
        fetba_pkg::t_rsp r;
        r = '0;
        r.status = st;
        r.entry_index = e[3:0];
        if (tbl_has_blk[e]) begin
            r.block_number = tbl_blk[e];
            r.block_valid = 1'b1;
        end
        return r;
    endfunction

    function automatic fetba_pkg::t_rsp apply_table_request(fetba_pkg::t_req rq);
        fetba_pkg::t_rsp r;
        int hit;
        int free_ent;
        int free_blk;
        r = '0;
        r.status = fetba_pkg::ST_NOT_FOUND;
        hit = -1;
        free_ent = -1;
        free_blk = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_id[i] == rq.file_id)
                hit = i;
            if (!tbl_valid[i])
                free_ent = i;
            if (free_blk < 0 && !blk_used[i])
                free_blk = i;
        end
        case (rq.kind)
            fetba_pkg::KIND_LOOKUP: begin
                if (hit >= 0)
                    r = entry_view(fetba_pkg::ST_OK, hit);
            end
            fetba_pkg::KIND_CREATE: begin
                if (hit >= 0) begin
                    r = entry_view(fetba_pkg::ST_EXISTS, hit);
                end else if (free_ent < 0) begin
                    r.status = fetba_pkg::ST_FULL;
                end else begin
                    tbl_valid[free_ent] = 1'b1;
                    tbl_id[free_ent] = rq.file_id;
                    if (free_blk >= 0) begin
                        blk_used[free_blk] = 1'b1;
                        tbl_blk[free_ent] = free_blk[3:0];
                        tbl_has_blk[free_ent] = 1'b1;
                        r = entry_view(fetba_pkg::ST_OK, free_ent);
                    end else begin
                        tbl_has_blk[free_ent] = 1'b0;
                        r.status = fetba_pkg::ST_NO_BLOCK;
                        r.entry_index = free_ent[3:0];
                    end
                end
            end
            fetba_pkg::KIND_DELETE: begin
                if (hit >= 0) begin
                    r = entry_view(fetba_pkg::ST_OK, hit);
                    if (tbl_has_blk[hit])
                        blk_used[tbl_blk[hit]] = 1'b0;
                    tbl_valid[hit] = 1'b0;
                    tbl_has_blk[hit] = 1'b0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // idle probability in percent; bursty in the middle, none near the end
    function automatic int idle_pct();
        if (pending_reqs.size() < QUIET_TAIL)
            return 0;
        case ((pending_reqs.size() / 150) % 3)
            0: return 0;
            1: return 20;
            default: return 50;
        endcase
    endfunction

    // request driver
    always @(negedge i_clk) begin : req_drv
        fetba_pkg::t_req nxt_req;
        logic nxt_vld;
        nxt_req = i_req;
        nxt_vld = i_req_valid;
        if (i_rst_n && (!i_req_valid || req_taken)) begin
            nxt_vld = 1'b0;
            if (req_gap > 0) begin
                req_gap <= req_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                if ($urandom_range(0, 99) < idle_pct()) begin
                    req_gap <= $urandom_range(0, 11);
                end else begin
                    nxt_req = pending_reqs.pop_front();
                    nxt_vld = 1'b1;
                end
            end
        end
        i_req_valid <= nxt_vld;
        i_req <= nxt_req;
    end

    // response ready with stall bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            i_rsp_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct()) begin
            rsp_stall <= $urandom_range(0, 11);
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    // monitor: check responses first, then model the request taken at this edge
    always @(posedge i_clk) begin : mon
        fetba_pkg::t_rsp exp_rsp;
        req_taken <= i_rst_n && i_req_valid && o_req_ready;
        if (i_rst_n) begin
            if (o_rsp_valid && i_rsp_ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("unexpected response: status %0d entry %0d block %0d bv %0d",
                           o_rsp.status, o_rsp.entry_index, o_rsp.block_number,
                           o_rsp.block_valid);
                    mismatches++;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (o_rsp.status !== exp_rsp.status) begin
                        $error("status: expected %0d actual %0d", exp_rsp.status,
                               o_rsp.status);
                        mismatches++;
                    end
                    if (o_rsp.entry_index !== exp_rsp.entry_index) begin
                        $error("entry_index: expected %0d actual %0d",
                               exp_rsp.entry_index, o_rsp.entry_index);
                        mismatches++;
                    end
                    if (o_rsp.block_number !== exp_rsp.block_number) begin
                        $error("block_number: expected %0d actual %0d",
                               exp_rsp.block_number, o_rsp.block_number);
                        mismatches++;
                    end
                    if (o_rsp.block_valid !== exp_rsp.block_valid) begin
                        $error("block_valid: expected %0d actual %0d",
                               exp_rsp.block_valid, o_rsp.block_valid);
                        mismatches++;
                    end
                end
            end
            if (i_req_valid && o_req_ready)
                expected_rsps.push_back(apply_table_request(i_req));
        end
    end

    task automatic queue_req(logic [1:0] kind, logic [fetba_pkg::FILE_ID_W-1:0] id);
        fetba_pkg::t_req rq;
        rq.kind = kind;
        rq.file_id = id;
        pending_reqs.push_back(rq);
    endtask

    initial begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL file_entry_table_with_block_allocator_top");
        $finish;
    end

    initial begin : stim
        logic [fetba_pkg::FILE_ID_W-1:0] id_pool[POOL_SIZE];
        logic [fetba_pkg::FILE_ID_W-1:0] id;
        logic [1:0]                      kind;
        int                              roll;
        logic                            fill_phase;

        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        i_rsp_ready = 1'b0;
        req_taken = 1'b0;
        req_gap = 0;
        rsp_stall = 0;
        mismatches = 0;
        cycle_cnt = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_id[i] = '0;
            tbl_blk[i] = '0;
            tbl_has_blk[i] = 1'b0;
            blk_used[i] = (i < 2);
        end

        // directed: misses, unused kind, duplicate, then fill until blockless and full
        queue_req(fetba_pkg::KIND_LOOKUP, 16'hFFFF);
        queue_req(KIND_UNUSED, 16'hFFFF);
        queue_req(fetba_pkg::KIND_DELETE, 16'h1234);
        queue_req(fetba_pkg::KIND_CREATE, 16'h0000);
        queue_req(fetba_pkg::KIND_CREATE, 16'hFFFF);
        queue_req(fetba_pkg::KIND_CREATE, 16'hFFFF);
        queue_req(fetba_pkg::KIND_LOOKUP, 16'h0000);
        queue_req(fetba_pkg::KIND_DELETE, 16'h0000);
        // 15 free entries, 13 free blocks: the last two end up blockless
        for (int i = 0; i < 15; i++)
            queue_req(fetba_pkg::KIND_CREATE, 16'h0001 << i);
        queue_req(fetba_pkg::KIND_CREATE, 16'h8000);
        queue_req(fetba_pkg::KIND_DELETE, 16'h4000);

        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = fetba_pkg::FILE_ID_W'($urandom_range(0, 16'hFFFF));

        // alternate fill-heavy and drain-heavy segments so the table swings
        // between empty and full
        for (int n = 0; n < RANDOM_REQS; n++) begin
            fill_phase = ((n / SEGMENT_LEN) % 2) == 0;
            roll = $urandom_range(0, 99);
            if (roll < 5)
                kind = KIND_UNUSED;
            else if (roll < (fill_phase ? 60 : 30))
                kind = fetba_pkg::KIND_CREATE;
            else if (roll < (fill_phase ? 80 : 75))
                kind = fetba_pkg::KIND_DELETE;
            else
                kind = fetba_pkg::KIND_LOOKUP;
            if ($urandom_range(0, 99) < 85)
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                id = fetba_pkg::FILE_ID_W'($urandom_range(0, 16'hFFFF));
            queue_req(kind, id);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || i_req_valid)
            @(posedge i_clk);
        while (expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS file_entry_table_with_block_allocator_top");
        else
            $display("FAIL file_entry_table_with_block_allocator_top");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/fetba_pkg.sv
hdl/fetba_cell.sv
hdl/file_entry_table_with_block_allocator_top.sv
hdl/fetba_chk.sv
test/file_entry_table_with_block_allocator_top_tb.sv
